>>> design/pwmt_pkg.sv
// Shared types and constants of the double-buffered PWM timer.
package pwmt_pkg;

    localparam int DATA_W      = 32;
    localparam int PRESCALE_W  = 8;
    localparam int DIV_SEL_W   = 3;
    localparam int DIV_CNT_W   = 4;
    localparam int CFG_INDEX_W = 2;
    localparam int OUT_TDATA_W = 40;

    localparam logic [DIV_SEL_W-1:0] DIV_SEL_MAX = 3'd4;

    // Bit positions inside the control word.
    localparam int CTRL_START  = 0;
    localparam int CTRL_UPDATE = 1;
    localparam int CTRL_RELOAD = 3;

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_CTRL     = 2'd1,
        OP_COUNT_WR = 2'd2,
        OP_CMP_WR   = 2'd3
    } t_op;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PRESCALE = 2'd0,
        CFG_DIVIDER  = 2'd1
    } t_cfg_index;

    typedef struct packed {
        logic              is_running;
        logic [DATA_W-1:0] count_observed;
        logic              interrupt_pulse;
        logic              pwm_level;
    } t_result;

endpackage

>>> design/pwmt_core.sv
// Timer state registers and the update applied for each request.
module pwmt_core
    import pwmt_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  t_op                   i_op,
    input  logic [DATA_W-1:0]     i_data,
    input  logic [PRESCALE_W-1:0] i_prescale_value,
    input  logic [DIV_SEL_W-1:0]  i_divider_select,
    output t_result               o_result
);

    logic [PRESCALE_W-1:0]  r_prescale_count, n_prescale_count;
    logic [DIV_CNT_W-1:0]   r_divide_count,   n_divide_count;
    logic [COUNT_WIDTH-1:0] r_down_count,     n_down_count;
    logic [COUNT_WIDTH-1:0] r_active_compare, n_active_compare;
    logic [COUNT_WIDTH-1:0] r_count_reload,   n_count_reload;
    logic [COUNT_WIDTH-1:0] r_compare_reload, n_compare_reload;
    logic                   r_output_level,   n_output_level;
    logic                   r_run_flag,       n_run_flag;
    logic                   r_reload_enable,  n_reload_enable;

    logic [DIV_SEL_W-1:0]   div_sel;
    logic [DIV_CNT_W-1:0]   div_last;
    logic [COUNT_WIDTH-1:0] dec_count;
    logic                   irq;
    logic                   reached_zero;

    always_comb begin
        n_prescale_count = r_prescale_count;
        n_divide_count   = r_divide_count;
        n_down_count     = r_down_count;
        n_active_compare = r_active_compare;
        n_count_reload   = r_count_reload;
        n_compare_reload = r_compare_reload;
        n_output_level   = r_output_level;
        n_run_flag       = r_run_flag;
        n_reload_enable  = r_reload_enable;
        irq              = 1'b0;
        reached_zero     = 1'b0;

        div_sel   = (i_divider_select > DIV_SEL_MAX) ? DIV_SEL_MAX : i_divider_select;
        div_last  = DIV_CNT_W'((5'd1 << div_sel) - 5'd1);
        dec_count = r_down_count - COUNT_WIDTH'(1);

        case (i_op)
            OP_TICK: begin
                if (r_run_flag) begin
                    if (r_prescale_count != i_prescale_value) begin
                        n_prescale_count = r_prescale_count + PRESCALE_W'(1);
                    end else begin
                        n_prescale_count = '0;
                        if (r_divide_count < div_last) begin
                            n_divide_count = r_divide_count + DIV_CNT_W'(1);
                        end else begin
                            n_divide_count = '0;
                            // A counter already at zero counts as reaching zero.
                            if (r_down_count != '0) begin
                                n_down_count = dec_count;
                                if (dec_count == r_active_compare) begin
                                    n_output_level = 1'b1;
                                end
                                reached_zero = (dec_count == '0);
                            end else begin
                                reached_zero = 1'b1;
                            end
                            if (reached_zero) begin
                                irq = 1'b1;
                                if (r_reload_enable) begin
                                    n_down_count     = r_count_reload;
                                    n_active_compare = r_compare_reload;
                                    n_output_level   = 1'b0;
                                end else begin
                                    n_run_flag = 1'b0;
                                end
                            end
                        end
                    end
                end
            end
            OP_CTRL: begin
                n_reload_enable = i_data[CTRL_RELOAD];
                if (i_data[CTRL_UPDATE]) begin
                    n_down_count     = r_count_reload;
                    n_active_compare = r_compare_reload;
                    n_output_level   = 1'b0;
                end
                n_run_flag = i_data[CTRL_START];
            end
            OP_COUNT_WR: begin
                n_count_reload = i_data[COUNT_WIDTH-1:0];
            end
            OP_CMP_WR: begin
                n_compare_reload = i_data[COUNT_WIDTH-1:0];
            end
            default: begin
                n_run_flag = r_run_flag;
            end
        endcase

        o_result.pwm_level       = n_output_level;
        o_result.interrupt_pulse = irq;
        o_result.count_observed  = DATA_W'(n_down_count);
        o_result.is_running      = n_run_flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prescale_count <= '0;
            r_divide_count   <= '0;
            r_down_count     <= '0;
            r_active_compare <= '0;
            r_count_reload   <= '0;
            r_compare_reload <= '0;
            r_output_level   <= 1'b0;
            r_run_flag       <= 1'b0;
            r_reload_enable  <= 1'b0;
        end else if (i_step) begin
            r_prescale_count <= n_prescale_count;
            r_divide_count   <= n_divide_count;
            r_down_count     <= n_down_count;
            r_active_compare <= n_active_compare;
            r_count_reload   <= n_count_reload;
            r_compare_reload <= n_compare_reload;
            r_output_level   <= n_output_level;
            r_run_flag       <= n_run_flag;
            r_reload_enable  <= n_reload_enable;
        end
    end

endmodule

>>> design/pwm_timer_double_buffered.sv
// Top level of the double-buffered PWM timer: request and result registers, configuration.
//
// Usage: each request on the slave stream is one timer event. s_axis_tuser carries the
// operation (tick, control write, count buffer write, compare buffer write) and
// s_axis_tdata the 32-bit write data. Every request yields exactly one result on the
// master stream with the output level, the interrupt pulse, the counter value and the
// run flag as they stand after that request.
// Configuration (prescale value at index 0, divider select at index 1) is written over
// the cfg channel, which is always ready; write it only while no request is in flight.
// A request passes the request register, then the timer update into the result register.
// Throughput is one request per cycle while the receiver takes every result.
// When the receiver stalls, the result register holds and the request register fills;
// s_axis_tready drops only when both are occupied and the result is not taken.
// A synchronous low reset stops the timer, clears all counters, buffers and
// configuration, and empties both registers.
module pwm_timer_double_buffered
    import pwmt_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Request stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [DATA_W-1:0]      s_axis_tdata,   // [31:0] write_data
    input  logic [1:0]             s_axis_tuser,   // [1:0] operation
    // Result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [0] pwm_level, [1] interrupt_pulse,
                                                   // [33:2] count_observed, [34] is_running
    // Configuration write channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [PRESCALE_W-1:0]  i_cfg_data
);

    logic                  r_in_valid;
    t_op                   r_in_op;
    logic [DATA_W-1:0]     r_in_data;
    logic                  r_out_valid;
    t_result               r_out_result;
    logic [PRESCALE_W-1:0] r_prescale_value;
    logic [DIV_SEL_W-1:0]  r_divider_select;

    logic    out_free;
    logic    step;
    t_result core_result;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign step          = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prescale_value <= '0;
            r_divider_select <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_PRESCALE: r_prescale_value <= i_cfg_data;
                CFG_DIVIDER:  r_divider_select <= i_cfg_data[DIV_SEL_W-1:0];
                default: begin
                    r_prescale_value <= r_prescale_value;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_op   <= t_op'(s_axis_tuser);
            r_in_data <= s_axis_tdata;
        end
    end

    pwmt_core #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (step),
        .i_op            (r_in_op),
        .i_data          (r_in_data),
        .i_prescale_value(r_prescale_value),
        .i_divider_select(r_divider_select),
        .o_result        (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_result <= core_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out_result);

endmodule

>>> design/pwmt_checker.sv
// Port-level checks of the PWM timer, bound to the top level.
module pwmt_checker
    import pwmt_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    t_result res;
    assign res = t_result'(m_axis_tdata[$bits(t_result)-1:0]);

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // A stalled result stays put.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // Stopping at zero leaves the counter at zero.
    a_stop_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && res.interrupt_pulse && !res.is_running |-> res.count_observed == '0)
        else $error("timer stopped with non-zero count");

    // A reload at zero drives the output low.
    a_reload_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && res.interrupt_pulse && res.is_running |-> !res.pwm_level)
        else $error("output high after reload");

endmodule

bind pwm_timer_double_buffered pwmt_checker u_pwmt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);

>>> tb/sv/pwm_timer_double_buffered_test.sv
// Self-checking testbench for the double-buffered PWM timer with its own timer predictor.
module pwm_timer_double_buffered_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pwmt_pkg::*;

    localparam int COUNT_W        = 32;
    localparam int RESET_CYCLES   = 5;
    localparam int DRAIN_CYCLES   = 10;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_PHASES  = 9;
    localparam int PHASE_REQUESTS = 100;
    localparam int RESULT_BITS    = $bits(t_result);
    localparam logic [DATA_W-1:0] CTRL_MASK =
        DATA_W'((1 << CTRL_START) | (1 << CTRL_UPDATE) | (1 << CTRL_RELOAD));

    typedef enum int {
        RX_FLOW,
        RX_RANDOM,
        RX_SPARSE,
        RX_BURSTY
    } t_rx_mode;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [DATA_W-1:0]      s_axis_tdata = '0;
    logic [1:0]             s_axis_tuser = OP_TICK;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = CFG_PRESCALE;
    logic [PRESCALE_W-1:0]  i_cfg_data = '0;

    // Predictor state, mirroring the timer after every accepted request.
    logic [PRESCALE_W-1:0] cfg_prescale = '0;
    logic [DIV_SEL_W-1:0]  cfg_div_sel = '0;
    logic [PRESCALE_W-1:0] prescale_cnt = '0;
    logic [DIV_CNT_W-1:0]  divide_cnt = '0;
    logic [COUNT_W-1:0]    down_cnt = '0;
    logic [COUNT_W-1:0]    active_cmp = '0;
    logic [COUNT_W-1:0]    count_buf = '0;
    logic [COUNT_W-1:0]    cmp_buf = '0;
    logic                  level = 1'b0;
    logic                  running = 1'b0;
    logic                  auto_reload = 1'b0;

    t_result  pending_results[$];
    int       mismatch_count = 0;
    int       burst_left = 0;
    int       idle_cycles = 0;
    int       rx_left = 0;
    int       rx_tick = 0;
    t_rx_mode rx_mode = RX_FLOW;

    pwm_timer_double_buffered #(
        .COUNT_WIDTH(COUNT_W)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void load_buffers();
        down_cnt   = count_buf;
        active_cmp = cmp_buf;
        level      = 1'b0;
    endfunction

    // A counter already at zero is treated as reaching zero without a decrement.
    function automatic logic count_down_once();
        if (down_cnt != '0) begin
            down_cnt = down_cnt - COUNT_W'(1);
            if (down_cnt == active_cmp) begin
                level = 1'b1;
            end
            if (down_cnt != '0) begin
                return 1'b0;
            end
        end
        if (auto_reload) begin
            load_buffers();
        end else begin
            running = 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic advance_tick();
        logic [DIV_SEL_W-1:0] sel;
        logic [DIV_CNT_W-1:0] last;
        if (!running) begin
            return 1'b0;
        end
        if (prescale_cnt != cfg_prescale) begin
            prescale_cnt = prescale_cnt + PRESCALE_W'(1);
            return 1'b0;
        end
        prescale_cnt = '0;
        sel  = (cfg_div_sel > DIV_SEL_MAX) ? DIV_SEL_MAX : cfg_div_sel;
        last = DIV_CNT_W'((1 << sel) - 1);
        if (divide_cnt < last) begin
            divide_cnt = divide_cnt + DIV_CNT_W'(1);
            return 1'b0;
        end
        divide_cnt = '0;
        return count_down_once();
    endfunction

    function automatic t_result timer_response(t_op op, logic [DATA_W-1:0] data);
        t_result res;
        logic    irq;
        irq = 1'b0;
        case (op)
            OP_TICK: begin
                irq = advance_tick();
            end
            OP_CTRL: begin
                auto_reload = data[CTRL_RELOAD];
                if (data[CTRL_UPDATE]) begin
                    load_buffers();
                end
                running = data[CTRL_START];
            end
            OP_COUNT_WR: begin
                count_buf = data[COUNT_W-1:0];
            end
            default: begin
                cmp_buf = data[COUNT_W-1:0];
            end
        endcase
        res.pwm_level       = level;
        res.interrupt_pulse = irq;
        res.count_observed  = DATA_W'(down_cnt);
        res.is_running      = running;
        return res;
    endfunction

    function automatic logic [DATA_W-1:0] ctrl_word(logic start, logic update, logic reload);
        logic [DATA_W-1:0] w;
        w              = '0;
        w[CTRL_START]  = start;
        w[CTRL_UPDATE] = update;
        w[CTRL_RELOAD] = reload;
        return w;
    endfunction

    // Mostly short counts so that interrupts come often, now and then a full-width value.
    function automatic logic [DATA_W-1:0] buffer_value();
        return ($urandom_range(7) == 0) ? DATA_W'($urandom) : DATA_W'($urandom_range(12));
    endfunction

    function automatic logic [DATA_W-1:0] random_ctrl();
        logic [DATA_W-1:0] junk;
        junk = ($urandom_range(3) == 0) ? (DATA_W'($urandom) & ~CTRL_MASK) : '0;
        return junk | ctrl_word($urandom_range(9) != 0, $urandom_range(1) != 0,
                                $urandom_range(3) != 0);
    endfunction

    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            if ($urandom_range(7) == 0) begin
                burst_left = $urandom_range(200, 80);
                gap = 0;
            end else begin
                burst_left = $urandom_range(24, 1);
                gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
            end
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
    endtask

    // Valid is left high on return so that back-to-back requests need no second assignment.
    task automatic send_request(t_op op, logic [DATA_W-1:0] data);
        pace_sender();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= data;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(timer_response(op, data));
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic write_register(t_cfg_index index, logic [PRESCALE_W-1:0] data);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (index)
            CFG_PRESCALE: cfg_prescale = data;
            CFG_DIVIDER:  cfg_div_sel = data[DIV_SEL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_and_start(logic [DATA_W-1:0] count, logic [DATA_W-1:0] cmp,
                                  logic [DATA_W-1:0] ctrl);
        send_request(OP_COUNT_WR, count);
        send_request(OP_CMP_WR, cmp);
        send_request(OP_CTRL, ctrl);
    endtask

    task automatic send_ticks(int n);
        repeat (n) send_request(OP_TICK, $urandom);
    endtask

    task automatic send_random_request();
        int pick;
        pick = $urandom_range(99);
        if (pick < 75) begin
            send_request(OP_TICK, $urandom);
        end else if (pick < 83) begin
            send_request(OP_COUNT_WR, buffer_value());
        end else if (pick < 91) begin
            send_request(OP_CMP_WR, buffer_value());
        end else begin
            send_request(OP_CTRL, random_ctrl());
        end
    endtask

    task automatic test_reload_cycle();
        write_register(CFG_PRESCALE, '0);
        write_register(CFG_DIVIDER, '0);
        load_and_start(3, 1, ctrl_word(1'b1, 1'b1, 1'b1));
        send_ticks(5);
    endtask

    // Compare at zero raises the output on the last count; without reload it stays high.
    task automatic test_compare_zero_stop();
        load_and_start(2, 0, ctrl_word(1'b1, 1'b1, 1'b0));
        send_ticks(4);
    endtask

    task automatic test_start_at_zero();
        send_request(OP_CTRL, ctrl_word(1'b1, 1'b0, 1'b0));
        send_ticks(2);
        send_request(OP_CTRL, ctrl_word(1'b1, 1'b0, 1'b1));
        send_ticks(1);
    endtask

    task automatic test_wide_values();
        load_and_start('1, 32'hFFFF_FFFE, '1);
        send_ticks(3);
        send_request(OP_CTRL, ~CTRL_MASK);
    endtask

    task automatic test_prescale_extreme();
        write_register(CFG_PRESCALE, '1);
        load_and_start(1, 0, ctrl_word(1'b1, 1'b1, 1'b0));
        send_ticks(260);
    endtask

    // A select above four must behave as a divider of sixteen.
    task automatic test_divider_saturation();
        write_register(CFG_PRESCALE, '0);
        write_register(CFG_DIVIDER, '1);
        load_and_start(2, 1, ctrl_word(1'b1, 1'b1, 1'b1));
        send_ticks(40);
    endtask

    task automatic test_unused_cfg_index();
        write_register(CFG_DIVIDER, '0);
        for (int k = CFG_DIVIDER + 1; k < (1 << CFG_INDEX_W); k++) begin
            write_register(t_cfg_index'(k), PRESCALE_W'($urandom));
        end
        load_and_start(2, 1, ctrl_word(1'b1, 1'b1, 1'b1));
        send_ticks(6);
    endtask

    task automatic test_random_traffic();
        logic [PRESCALE_W-1:0] prescale;
        logic [PRESCALE_W-1:0] div_data;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            prescale = ($urandom_range(5) == 0) ? PRESCALE_W'($urandom)
                                                : PRESCALE_W'($urandom_range(2));
            div_data = PRESCALE_W'($urandom);
            if ($urandom_range(3) != 0) begin
                div_data[DIV_SEL_W-1:0] = DIV_SEL_W'($urandom_range(2));
            end
            write_register(CFG_PRESCALE, prescale);
            write_register(CFG_DIVIDER, div_data);
            load_and_start(buffer_value(), buffer_value(),
                           ctrl_word(1'b1, 1'b1, $urandom_range(3) != 0));
            repeat (PHASE_REQUESTS) send_random_request();
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reload_cycle();
        test_compare_zero_stop();
        test_start_at_zero();
        test_wide_values();
        test_prescale_extreme();
        test_divider_saturation();
        test_unused_cfg_index();
        test_random_traffic();
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("pwm_timer_double_buffered_test: PASS");
        end else begin
            $display("pwm_timer_double_buffered_test: FAIL");
        end
        $finish;
    end

    // The receiver switches between stall patterns, holding each for a random span.
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(3));
            rx_left <= $urandom_range(200, 40);
        end else begin
            rx_left <= rx_left - 1;
        end
        rx_tick <= rx_tick + 1;
        case (rx_mode)
            RX_FLOW:   m_axis_tready <= 1'b1;
            RX_RANDOM: m_axis_tready <= 1'($urandom_range(1));
            RX_SPARSE: m_axis_tready <= (rx_tick % 4) == 0;
            default:   m_axis_tready <= (rx_tick % 24) >= 18;
        endcase
    end

    function automatic void check_field(string name, logic [DATA_W-1:0] want,
                                        logic [DATA_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin : check_results
        t_result want;
        t_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata[RESULT_BITS-1:0]);
            if (pending_results.size() == 0) begin
                $display("%0t: result with no request waiting, expected none, actual %h",
                         $time, m_axis_tdata);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("pwm_level", DATA_W'(want.pwm_level), DATA_W'(got.pwm_level));
                check_field("interrupt_pulse", DATA_W'(want.interrupt_pulse),
                            DATA_W'(got.interrupt_pulse));
                check_field("count_observed", want.count_observed, got.count_observed);
                check_field("is_running", DATA_W'(want.is_running), DATA_W'(got.is_running));
                check_field("tdata padding", '0,
                            DATA_W'(m_axis_tdata[OUT_TDATA_W-1:RESULT_BITS]));
            end
        end
    end

    // Stall patterns and sender gaps are far shorter than this, so a hit means a hang.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("pwm_timer_double_buffered_test: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
